[rtl/core/hzs_pkg.sv]
package hzs_pkg;

  localparam int GPR_COUNT  = 16;
  localparam int CTRL_COUNT = 32;

  localparam int GprIdxW  = (GPR_COUNT > 1) ? $clog2(GPR_COUNT) : 1;
  localparam int CtrlIdxW = (CTRL_COUNT > 1) ? $clog2(CTRL_COUNT) : 1;

  localparam int CntW = 9;

  // fixed completion delays on top of exec_cycles
  localparam logic [CntW-1:0] BRANCH_DLY = 9'd2;
  localparam logic [CntW-1:0] SHORT_DLY  = 9'd1;
  localparam logic [CntW-1:0] LATE_DLY   = 9'd2;
  localparam logic [CntW-1:0] HILO_DLY   = 9'd34;
  localparam logic [CntW-1:0] UNIT_DLY   = 9'd36;

  // register indexes on the APB port
  localparam logic REG_HI = 1'b0;
  localparam logic REG_LO = 1'b1;

  localparam logic [4:0] HI_RST = 5'd7;
  localparam logic [4:0] LO_RST = 5'd8;

  typedef enum logic [3:0] {
    ACT_USE_GPR   = 4'd0,
    ACT_USE_CTRL  = 4'd1,
    ACT_USE_MUL   = 4'd2,
    ACT_USE_DIV   = 4'd3,
    ACT_USE_LDCB  = 4'd4,
    ACT_BRANCH    = 4'd5,
    ACT_MUL_DONE  = 4'd6,
    ACT_STCB_DONE = 4'd7,
    ACT_DIV_DONE  = 4'd8,
    ACT_LOAD_GPR  = 4'd9,
    ACT_LATE_GPR  = 4'd10,
    ACT_TICK      = 4'd11
  } action_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [4:0]  reg_index;
    logic [7:0]  exec_cycles;
    logic        branch_taken;
    logic [15:0] elapsed;
  } hzs_item_t;

  typedef struct packed {
    logic [4:0] hi_idx;
    logic [4:0] lo_idx;
  } hzs_cfg_t;

  function automatic logic [CntW-1:0] raise_fn(input logic [CntW-1:0] cur,
                                               input logic [CntW-1:0] v);
    return (v > cur) ? v : cur;
  endfunction

  // saturating countdown drain
  function automatic logic [CntW-1:0] drain_fn(input logic [CntW-1:0] c,
                                               input logic [15:0] n);
    logic [15:0] ext;
    ext = 16'(c);
    return (ext > n) ? CntW'(ext - n) : '0;
  endfunction

endpackage

[rtl/core/hzs_cfg_regs.sv]
module hzs_cfg_regs
  import hzs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output hzs_cfg_t    cfg
);

  logic [4:0] hi_idx_r, hi_idx_nxt;
  logic [4:0] lo_idx_r, lo_idx_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    hi_idx_nxt = hi_idx_r;
    lo_idx_nxt = lo_idx_r;
    if (wr_en) begin
      case (paddr[2])
        REG_HI:  hi_idx_nxt = pwdata[4:0];
        REG_LO:  lo_idx_nxt = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_idx_r <= HI_RST;
      lo_idx_r <= LO_RST;
    end else begin
      hi_idx_r <= hi_idx_nxt;
      lo_idx_r <= lo_idx_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HI:  prdata = {27'd0, hi_idx_r};
      REG_LO:  prdata = {27'd0, lo_idx_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.hi_idx = hi_idx_r;
  assign cfg.lo_idx = lo_idx_r;

endmodule

[rtl/core/hzs_countdown_bank.sv]
module hzs_countdown_bank
  import hzs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  hzs_item_t       item,
  input  hzs_cfg_t        cfg,
  output logic [CntW-1:0] stall_nxt
);

  logic [CntW-1:0] gpr_r  [GPR_COUNT];
  logic [CntW-1:0] gpr_nxt [GPR_COUNT];
  logic [CntW-1:0] ctrl_r [CTRL_COUNT];
  logic [CntW-1:0] ctrl_nxt [CTRL_COUNT];
  logic [CntW-1:0] mul_r, mul_nxt;
  logic [CntW-1:0] div_r, div_nxt;
  logic [CntW-1:0] ldcb_r, ldcb_nxt;
  logic [CntW-1:0] stall_r;

  logic                gpr_hit, ctrl_hit, hi_hit, lo_hit;
  logic [GprIdxW-1:0]  gpr_idx;
  logic [CtrlIdxW-1:0] ctrl_idx, hi_idx, lo_idx;
  logic [CntW-1:0]     cyc;

  assign cyc      = CntW'(item.exec_cycles);
  assign gpr_hit  = 32'(item.reg_index) < 32'(GPR_COUNT);
  assign ctrl_hit = 32'(item.reg_index) < 32'(CTRL_COUNT);
  assign hi_hit   = 32'(cfg.hi_idx) < 32'(CTRL_COUNT);
  assign lo_hit   = 32'(cfg.lo_idx) < 32'(CTRL_COUNT);
  assign gpr_idx  = GprIdxW'(item.reg_index);
  assign ctrl_idx = CtrlIdxW'(item.reg_index);
  assign hi_idx   = CtrlIdxW'(cfg.hi_idx);
  assign lo_idx   = CtrlIdxW'(cfg.lo_idx);

  always_comb begin
    gpr_nxt   = gpr_r;
    ctrl_nxt  = ctrl_r;
    mul_nxt   = mul_r;
    div_nxt   = div_r;
    ldcb_nxt  = ldcb_r;
    stall_nxt = stall_r;
    case (action_t'(item.action))
      ACT_USE_GPR: begin
        if (gpr_hit) stall_nxt = raise_fn(stall_r, gpr_r[gpr_idx]);
      end
      ACT_USE_CTRL: begin
        if (ctrl_hit) stall_nxt = raise_fn(stall_r, ctrl_r[ctrl_idx]);
      end
      ACT_USE_MUL:  stall_nxt = raise_fn(stall_r, mul_r);
      ACT_USE_DIV:  stall_nxt = raise_fn(stall_r, div_r);
      ACT_USE_LDCB: stall_nxt = raise_fn(stall_r, ldcb_r);
      ACT_BRANCH: begin
        if (item.branch_taken) stall_nxt = raise_fn(stall_r, cyc + BRANCH_DLY);
      end
      ACT_MUL_DONE:  div_nxt  = cyc + SHORT_DLY;
      ACT_STCB_DONE: ldcb_nxt = cyc + SHORT_DLY;
      ACT_DIV_DONE: begin
        if (hi_hit) ctrl_nxt[hi_idx] = cyc + HILO_DLY;
        if (lo_hit) ctrl_nxt[lo_idx] = cyc + HILO_DLY;
        div_nxt = cyc + UNIT_DLY;
        mul_nxt = cyc + UNIT_DLY;
      end
      ACT_LOAD_GPR: begin
        if (gpr_hit) gpr_nxt[gpr_idx] = cyc + SHORT_DLY;
      end
      ACT_LATE_GPR: begin
        if (gpr_hit) gpr_nxt[gpr_idx] = cyc + LATE_DLY;
      end
      ACT_TICK: begin
        // zero elapsed drains nothing, so no special case needed
        for (int i = 0; i < GPR_COUNT; i++) gpr_nxt[i] = drain_fn(gpr_r[i], item.elapsed);
        for (int i = 0; i < CTRL_COUNT; i++) ctrl_nxt[i] = drain_fn(ctrl_r[i], item.elapsed);
        mul_nxt   = drain_fn(mul_r, item.elapsed);
        div_nxt   = drain_fn(div_r, item.elapsed);
        ldcb_nxt  = drain_fn(ldcb_r, item.elapsed);
        stall_nxt = drain_fn(stall_r, item.elapsed);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GPR_COUNT; i++) gpr_r[i] <= '0;
      for (int i = 0; i < CTRL_COUNT; i++) ctrl_r[i] <= '0;
      mul_r   <= '0;
      div_r   <= '0;
      ldcb_r  <= '0;
      stall_r <= '0;
    end else if (upd) begin
      gpr_r   <= gpr_nxt;
      ctrl_r  <= ctrl_nxt;
      mul_r   <= mul_nxt;
      div_r   <= div_nxt;
      ldcb_r  <= ldcb_nxt;
      stall_r <= stall_nxt;
    end
  end

endmodule

[rtl/core/pipeline_hazard_scoreboard_unit.sv]
// out_valid rises once an accepted item has passed the input register and then the result register.
// One item per cycle while the result side does not stall; the scoreboard update is a single pass per item.
// All countdowns update in parallel, so ticks cost the same as any other item.
// Reset (rst_n low, synchronous): all countdowns and the stall count clear,
// both stages empty, hi/lo control register numbers return to 7 and 8.
module pipeline_hazard_scoreboard_unit
  import hzs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [4:0]  in_reg_index,
  input  logic [7:0]  in_exec_cycles,
  input  logic        in_branch_taken,
  input  logic [15:0] in_elapsed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_stall_cycles,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hzs_cfg_t        cfg;
  hzs_item_t       item_r;
  logic            item_vld_r, item_vld_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [CntW-1:0] stall_cyc_r;
  logic [CntW-1:0] stall_nxt;
  logic            out_free, fire, accept;

  hzs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register free or draining this cycle
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = item_vld_r && out_free;
  assign in_stall = item_vld_r && !out_free;
  assign accept   = in_valid && !in_stall;

  hzs_countdown_bank u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (fire),
    .item      (item_r),
    .cfg       (cfg),
    .stall_nxt (stall_nxt)
  );

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (accept)    item_vld_nxt = 1'b1;
    else if (fire) item_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (fire)          out_vld_nxt = 1'b1;
    else if (!out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action       <= in_action;
      item_r.reg_index    <= in_reg_index;
      item_r.exec_cycles  <= in_exec_cycles;
      item_r.branch_taken <= in_branch_taken;
      item_r.elapsed      <= in_elapsed;
    end
    if (fire) stall_cyc_r <= stall_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_stall_cycles = stall_cyc_r;

endmodule

[rtl/core/hzs_checker.sv]
module hzs_checker
  import hzs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [3:0]  in_action,
  input logic [15:0] in_elapsed,
  input logic        out_valid,
  input logic        out_stall,
  input logic [8:0]  out_stall_cycles
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stall_cycles))
    else $error("result changed while stalled");

  // back-pressure only ever comes from the result side
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled with result side free");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a tick at least as long as any countdown leaves a zero stall count in the result
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_TICK && in_elapsed >= 16'd511
    ##1 !out_stall |=> out_valid && out_stall_cycles == 9'd0)
    else $error("long tick did not clear the stall count");

endmodule

bind pipeline_hazard_scoreboard_unit hzs_checker u_hzs_checker (.*);
